@@ hw/rtl/cpts_pkg.sv @@
// ----------------------------------------------------------------------------
// cpts_pkg: shared types and constants for the cyclic prefix timing search
// Buffer and sample sizes, register codes, controller and unit state types,
// command/status words and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package cpts_pkg;

  // Sizing
  localparam int BUFFER_DEPTH   = 16384;
  localparam int MAX_SYMBOL_LEN = 1024;
  localparam int SAMPLE_BITS    = 16;

  localparam int ADDR_W     = $clog2(BUFFER_DEPTH);
  localparam int OFF_W      = $clog2(MAX_SYMBOL_LEN);
  localparam int NOFF_W     = OFF_W + 1;
  localparam int IN_W       = 16;
  localparam int UL_W       = 10;
  localparam int GL_W       = 9;
  localparam int SC_W       = 4;
  localparam int BOUND_W    = 48;
  localparam int TS_W       = UL_W + 1;
  localparam int NEED_W     = 16;
  localparam int COUNT_W    = 15;
  localparam int ACC_W      = 48;
  localparam int MAG_W      = ACC_W;
  localparam int METRIC_W   = ACC_W + 1;
  localparam int RATIO_W    = 16;
  localparam int PHASE_W    = 16;
  localparam int ANG_W      = 18;
  localparam int MAG_CNT_W  = $clog2(MAG_W);
  localparam int STEP_W     = 4;
  localparam int RATIO_STEPS  = 16;
  localparam int CORDIC_STEPS = 15;
  localparam int CORDIC_IN_BITS = 30;
  localparam int QUARTER_TURN   = 16384;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_USEFUL_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_LEN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_METRIC_BOUND = 2'd3;

  localparam logic [UL_W-1:0]    USEFUL_LEN_RST   = 10'd288;
  localparam logic [GL_W-1:0]    GUARD_LEN_RST    = 9'd32;
  localparam logic [SC_W-1:0]    SYMBOL_COUNT_RST = 4'd15;
  localparam logic [BOUND_W-1:0] METRIC_BOUND_RST = '1;

  // Controller states
  typedef enum logic [3:0] {
    ST_CAPTURE,
    ST_INIT,
    ST_OFF_START,
    ST_RUN,
    ST_DRAIN,
    ST_MAG,
    ST_METRIC,
    ST_CMP,
    ST_POST,
    ST_PWAIT,
    ST_OUT
  } ctrl_state_t;

  // Magnitude unit phases
  typedef enum logic [1:0] {
    MAG_IDLE,
    MAG_SQ,
    MAG_ROOT
  } mag_phase_t;

  // Ratio / phase unit phases
  typedef enum logic [2:0] {
    P_IDLE,
    P_RATIO,
    P_SHIFT,
    P_QUAD,
    P_ROT,
    P_DONE
  } post_phase_t;

  // Register values seen by the datapath
  typedef struct packed {
    logic [UL_W-1:0]    useful_len;
    logic [BOUND_W-1:0] metric_bound;
  } cpts_cfg_t;

  // Commands from the controller
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              acc_clear;
    logic              mag_start;
    logic              best_init;
    logic              metric_load;
    logic              best_update;
    logic              first;
    logic [OFF_W-1:0]  offset;
    logic              post_start;
    logic              res_load;
  } cpts_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic corr_busy;
    logic mag_done;
    logic post_done;
    logic out_free;
  } cpts_stat_t;

  // atan(2^-i) in units of pi/32768, rounded
  function automatic logic [ANG_W-1:0] atan_unit(input logic [STEP_W-1:0] i);
    logic [ANG_W-1:0] r;
    case (i)
      4'd0:    r = 18'd8192;
      4'd1:    r = 18'd4836;
      4'd2:    r = 18'd2555;
      4'd3:    r = 18'd1297;
      4'd4:    r = 18'd651;
      4'd5:    r = 18'd326;
      4'd6:    r = 18'd163;
      4'd7:    r = 18'd81;
      4'd8:    r = 18'd41;
      4'd9:    r = 18'd20;
      4'd10:   r = 18'd10;
      4'd11:   r = 18'd5;
      4'd12:   r = 18'd3;
      4'd13:   r = 18'd1;
      4'd14:   r = 18'd1;
      default: r = 18'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/cpts_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpts_ctrl: capture and search sequencer
// Holds the configuration registers and capture count, walks offsets,
// symbols and guard terms, and steps the datapath units through each offset.
// ----------------------------------------------------------------------------
module cpts_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cpts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpts_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cpts_pkg::cpts_stat_t             stat,
  output cpts_pkg::cpts_cmd_t              cmd,
  output cpts_pkg::cpts_cfg_t              cfg
);

  cpts_pkg::ctrl_state_t state, state_next;

  logic [cpts_pkg::UL_W-1:0]    useful_len;
  logic [cpts_pkg::GL_W-1:0]    guard_len;
  logic [cpts_pkg::SC_W-1:0]    symbol_count;
  logic [cpts_pkg::BOUND_W-1:0] metric_bound;

  logic [cpts_pkg::COUNT_W-1:0] count;
  logic [cpts_pkg::OFF_W-1:0]   m;
  logic [cpts_pkg::SC_W-1:0]    j;
  logic [cpts_pkg::GL_W-1:0]    k;
  logic [cpts_pkg::ADDR_W-1:0]  row;
  logic [cpts_pkg::ADDR_W-1:0]  addr;

  logic [cpts_pkg::TS_W-1:0]    ts;
  logic [cpts_pkg::SC_W:0]      sc_p1;
  logic [cpts_pkg::NEED_W-1:0]  need;
  logic [cpts_pkg::COUNT_W:0]   count_inc;
  logic [cpts_pkg::COUNT_W-1:0] count_wrap;
  logic                         cap_done;
  logic [15:0]                  ts_wide;
  logic [cpts_pkg::NOFF_W-1:0]  noff;
  logic [cpts_pkg::NOFF_W-1:0]  m_inc;
  logic [cpts_pkg::ADDR_W-1:0]  row_adv;
  logic                         k_last;
  logic                         j_last;
  logic                         no_terms;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      useful_len   <= cpts_pkg::USEFUL_LEN_RST;
      guard_len    <= cpts_pkg::GUARD_LEN_RST;
      symbol_count <= cpts_pkg::SYMBOL_COUNT_RST;
      metric_bound <= cpts_pkg::METRIC_BOUND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cpts_pkg::REG_USEFUL_LEN:   useful_len   <= cfg_data[cpts_pkg::UL_W-1:0];
        cpts_pkg::REG_GUARD_LEN:    guard_len    <= cfg_data[cpts_pkg::GL_W-1:0];
        cpts_pkg::REG_SYMBOL_COUNT: symbol_count <= cfg_data[cpts_pkg::SC_W-1:0];
        cpts_pkg::REG_METRIC_BOUND: metric_bound <= cfg_data[cpts_pkg::BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.useful_len   = useful_len;
  assign cfg.metric_bound = metric_bound;

  // Frame geometry
  assign ts         = cpts_pkg::TS_W'(useful_len) + cpts_pkg::TS_W'(guard_len);
  assign sc_p1      = {1'b0, symbol_count} + 1'b1;
  assign need       = cpts_pkg::NEED_W'(sc_p1) * cpts_pkg::NEED_W'(ts);
  assign count_inc  = {1'b0, count} + 1'b1;
  assign count_wrap = count_inc[cpts_pkg::COUNT_W-1:0];
  assign cap_done   = cpts_pkg::NEED_W'({1'b0, count_wrap}) >= need;
  assign ts_wide    = 16'(ts);
  assign noff       = (ts_wide < 16'(cpts_pkg::MAX_SYMBOL_LEN)) ?
                      cpts_pkg::NOFF_W'(ts) : cpts_pkg::NOFF_W'(cpts_pkg::MAX_SYMBOL_LEN);
  assign m_inc      = {1'b0, m} + 1'b1;
  assign row_adv    = row + cpts_pkg::ADDR_W'(ts);
  assign k_last     = (k == guard_len - 1'b1);
  assign j_last     = (j == symbol_count - 1'b1);
  assign no_terms   = (guard_len == '0) || (symbol_count == '0);

  assign in_stall = (state != cpts_pkg::ST_CAPTURE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpts_pkg::ST_CAPTURE;
    end else begin
      state <= state_next;
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      m     <= '0;
      j     <= '0;
      k     <= '0;
      row   <= '0;
      addr  <= '0;
    end else begin
      case (state)
        cpts_pkg::ST_CAPTURE: begin
          if (in_valid) begin
            count <= cap_done ? '0 : count_wrap;
          end
        end
        cpts_pkg::ST_INIT: begin
          m <= '0;
        end
        cpts_pkg::ST_OFF_START: begin
          j    <= '0;
          k    <= '0;
          row  <= cpts_pkg::ADDR_W'(m);
          addr <= cpts_pkg::ADDR_W'(m);
        end
        cpts_pkg::ST_RUN: begin
          if (k_last) begin
            k    <= '0;
            j    <= j + 1'b1;
            row  <= row_adv;
            addr <= row_adv;
          end else begin
            k    <= k + 1'b1;
            addr <= addr + 1'b1;
          end
        end
        cpts_pkg::ST_CMP: begin
          m <= m + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.wr_addr = count[cpts_pkg::ADDR_W-1:0];
    cmd.rd_addr = addr;
    cmd.offset  = m;
    cmd.first   = (m == '0);
    case (state)
      cpts_pkg::ST_CAPTURE: begin
        if (in_valid) begin
          cmd.wr_en = 1'b1;
          if (cap_done) begin
            state_next = cpts_pkg::ST_INIT;
          end
        end
      end
      cpts_pkg::ST_INIT: begin
        cmd.best_init = 1'b1;
        state_next = (noff == '0) ? cpts_pkg::ST_POST : cpts_pkg::ST_OFF_START;
      end
      cpts_pkg::ST_OFF_START: begin
        cmd.acc_clear = 1'b1;
        state_next = no_terms ? cpts_pkg::ST_DRAIN : cpts_pkg::ST_RUN;
      end
      cpts_pkg::ST_RUN: begin
        cmd.rd_en = 1'b1;
        if (k_last && j_last) begin
          state_next = cpts_pkg::ST_DRAIN;
        end
      end
      cpts_pkg::ST_DRAIN: begin
        if (!stat.corr_busy) begin
          cmd.mag_start = 1'b1;
          state_next = cpts_pkg::ST_MAG;
        end
      end
      cpts_pkg::ST_MAG: begin
        if (stat.mag_done) begin
          state_next = cpts_pkg::ST_METRIC;
        end
      end
      cpts_pkg::ST_METRIC: begin
        cmd.metric_load = 1'b1;
        state_next = cpts_pkg::ST_CMP;
      end
      cpts_pkg::ST_CMP: begin
        cmd.best_update = 1'b1;
        state_next = (m_inc == noff) ? cpts_pkg::ST_POST : cpts_pkg::ST_OFF_START;
      end
      cpts_pkg::ST_POST: begin
        cmd.post_start = 1'b1;
        state_next = cpts_pkg::ST_PWAIT;
      end
      cpts_pkg::ST_PWAIT: begin
        if (stat.post_done) begin
          state_next = cpts_pkg::ST_OUT;
        end
      end
      cpts_pkg::ST_OUT: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next = cpts_pkg::ST_CAPTURE;
        end
      end
      default: state_next = cpts_pkg::ST_CAPTURE;
    endcase
  end

endmodule

@@ hw/rtl/cpts_corr.sv @@
// ----------------------------------------------------------------------------
// cpts_corr: sample store and correlation/energy accumulation
// Dual-read sample memory, registered products and term sums, and the
// three accumulators of one candidate offset.
// ----------------------------------------------------------------------------
module cpts_corr (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cpts_pkg::cpts_cmd_t                   cmd,
  input  cpts_pkg::cpts_cfg_t                   cfg,
  input  logic signed [cpts_pkg::IN_W-1:0]      sample_i,
  input  logic signed [cpts_pkg::IN_W-1:0]      sample_q,
  output logic signed [cpts_pkg::ACC_W-1:0]     acc_re,
  output logic signed [cpts_pkg::ACC_W-1:0]     acc_im,
  output logic        [cpts_pkg::ACC_W-1:0]     acc_en,
  output logic                                  busy
);

  localparam int S  = cpts_pkg::SAMPLE_BITS;
  localparam int PW = 2 * S;
  localparam int TW = 2 * S + 1;
  localparam int EW = 2 * S + 2;

  logic [2*S-1:0] store [cpts_pkg::BUFFER_DEPTH];
  logic [2*S-1:0] rd_a;
  logic [2*S-1:0] rd_b;
  logic [cpts_pkg::ADDR_W-1:0] addr_b;
  logic v1, v2, v3;

  logic signed [S-1:0] i1, q1, i2, q2;
  logic signed [PW-1:0] p_ii, p_qq, p_qi, p_iq, e_i1, e_q1, e_i2, e_q2;
  logic signed [TW-1:0] t_re, t_im;
  logic [EW-1:0] t_en;

  assign addr_b = cmd.rd_addr + cpts_pkg::ADDR_W'(cfg.useful_len);

  // Sample memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store[cmd.wr_addr] <= {sample_i[S-1:0], sample_q[S-1:0]};
    end
    rd_a <= store[cmd.rd_addr];
    rd_b <= store[addr_b];
  end

  assign i1 = signed'(rd_a[2*S-1:S]);
  assign q1 = signed'(rd_a[S-1:0]);
  assign i2 = signed'(rd_b[2*S-1:S]);
  assign q2 = signed'(rd_b[S-1:0]);

  // Products
  always_ff @(posedge clk) begin
    p_ii <= i1 * i2;
    p_qq <= q1 * q2;
    p_qi <= q1 * i2;
    p_iq <= i1 * q2;
    e_i1 <= i1 * i1;
    e_q1 <= q1 * q1;
    e_i2 <= i2 * i2;
    e_q2 <= q2 * q2;
  end

  // Term sums
  always_ff @(posedge clk) begin
    t_re <= TW'(p_ii) + TW'(p_qq);
    t_im <= TW'(p_qi) - TW'(p_iq);
    t_en <= EW'(unsigned'(e_i1)) + EW'(unsigned'(e_q1)) +
            EW'(unsigned'(e_i2)) + EW'(unsigned'(e_q2));
  end

  // Valid tags through the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign busy = v1 | v2 | v3;

  // Accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.acc_clear) begin
      acc_re <= '0;
      acc_im <= '0;
      acc_en <= '0;
    end else if (v3) begin
      acc_re <= acc_re + cpts_pkg::ACC_W'(t_re);
      acc_im <= acc_im + cpts_pkg::ACC_W'(t_im);
      acc_en <= acc_en + cpts_pkg::ACC_W'(t_en);
    end
  end

endmodule

@@ hw/rtl/cpts_mag.sv @@
// ----------------------------------------------------------------------------
// cpts_mag: complex magnitude unit
// floor(sqrt(re^2 + im^2)): squares from six half-width partial products,
// then a digit-by-digit square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module cpts_mag (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [cpts_pkg::ACC_W-1:0]  re,
  input  logic signed [cpts_pkg::ACC_W-1:0]  im,
  output logic        [cpts_pkg::MAG_W-1:0]  mag,
  output logic                               done
);

  localparam int W     = cpts_pkg::ACC_W;
  localparam int H     = W / 2;
  localparam int RAD_W = 2 * W;
  localparam int REM_W = cpts_pkg::MAG_W + 2;
  localparam int RS_W  = REM_W + 2;

  cpts_pkg::mag_phase_t phase;

  logic [W-1:0] mag_a, mag_b, src;
  logic [H-1:0] op1, op2;
  logic [RAD_W-1:0] prod_sh, prod_next, rad;
  logic pv;
  logic [cpts_pkg::MAG_CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  logic [RS_W-1:0] rem_s, trial;
  logic ge;

  // Partial product selection: lo*lo, hi*lo doubled, hi*hi
  always_comb begin
    src = (cnt < 3) ? mag_a : mag_b;
    op1 = src[W-1:H];
    op2 = src[H-1:0];
    prod_next = '0;
    case (cnt)
      cpts_pkg::MAG_CNT_W'(0), cpts_pkg::MAG_CNT_W'(3):
        prod_next = RAD_W'(src[H-1:0] * src[H-1:0]);
      cpts_pkg::MAG_CNT_W'(1), cpts_pkg::MAG_CNT_W'(4):
        prod_next = RAD_W'(op1 * op2) << (H + 1);
      cpts_pkg::MAG_CNT_W'(2), cpts_pkg::MAG_CNT_W'(5):
        prod_next = RAD_W'(op1 * op1) << W;
      default:    prod_next = '0;
    endcase
  end

  // Root step
  assign rem_s = {rem, rad[RAD_W-1 -: 2]};
  assign trial = RS_W'({mag, 2'b01});
  assign ge    = rem_s >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cpts_pkg::MAG_IDLE;
      done  <= 1'b0;
      pv    <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (phase)
        cpts_pkg::MAG_IDLE: begin
          if (start) begin
            mag_a <= re[W-1] ? W'(-re) : W'(re);
            mag_b <= im[W-1] ? W'(-im) : W'(im);
            rad   <= '0;
            cnt   <= '0;
            pv    <= 1'b0;
            phase <= cpts_pkg::MAG_SQ;
          end
        end
        cpts_pkg::MAG_SQ: begin
          if (pv) begin
            rad <= rad + prod_sh;
          end
          if (cnt < 6) begin
            prod_sh <= prod_next;
            pv      <= 1'b1;
            cnt     <= cnt + 1'b1;
          end else begin
            pv    <= 1'b0;
            cnt   <= '0;
            rem   <= '0;
            mag   <= '0;
            phase <= cpts_pkg::MAG_ROOT;
          end
        end
        cpts_pkg::MAG_ROOT: begin
          rem <= ge ? REM_W'(rem_s - trial) : REM_W'(rem_s);
          mag <= {mag[cpts_pkg::MAG_W-2:0], ge};
          rad <= rad << 2;
          cnt <= cnt + 1'b1;
          if (cnt == cpts_pkg::MAG_CNT_W'(cpts_pkg::MAG_W - 1)) begin
            done  <= 1'b1;
            phase <= cpts_pkg::MAG_IDLE;
          end
        end
        default: phase <= cpts_pkg::MAG_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/cpts_eval.sv @@
// ----------------------------------------------------------------------------
// cpts_eval: metric, best offset tracking and result formatting
// Timing metric |E - 2M|, first-minimum tracking against the bound,
// iterative Q0.16 ratio, CORDIC phase and the result word register.
// ----------------------------------------------------------------------------
module cpts_eval (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cpts_pkg::cpts_cmd_t                   cmd,
  input  cpts_pkg::cpts_cfg_t                   cfg,
  input  logic signed [cpts_pkg::ACC_W-1:0]     acc_re,
  input  logic signed [cpts_pkg::ACC_W-1:0]     acc_im,
  input  logic        [cpts_pkg::ACC_W-1:0]     acc_en,
  input  logic        [cpts_pkg::MAG_W-1:0]     mag,
  input  logic                                  out_stall,
  output logic                                  post_done,
  output logic                                  out_free,
  output logic                                  out_valid,
  output logic [cpts_pkg::OFF_W-1:0]            best_offset,
  output logic [cpts_pkg::RATIO_W-1:0]          corr_ratio,
  output logic signed [cpts_pkg::PHASE_W-1:0]   corr_phase
);

  localparam int W  = cpts_pkg::ACC_W;
  localparam int DW = W + 2;

  cpts_pkg::post_phase_t phase;

  logic [cpts_pkg::METRIC_W-1:0] metric, best_metric;
  logic [cpts_pkg::OFF_W-1:0]    best_index;
  logic signed [W-1:0]           b_re, b_im;
  logic [W-1:0]                  b_en;
  logic [cpts_pkg::MAG_W-1:0]    b_mag;

  logic [DW-1:0] dif, dif_abs;
  logic [DW-1:0] rt;
  logic [W-1:0]  ua, ub;

  logic [W-1:0]                  rm;
  logic [cpts_pkg::RATIO_W-1:0]  q;
  logic signed [W-1:0]           x, y, dx, dy;
  logic [W-1:0]                  mx;
  logic signed [cpts_pkg::ANG_W-1:0] ang, atan_s;
  logic [cpts_pkg::STEP_W-1:0]   pc;

  // Metric |E - 2M|
  assign dif     = {2'b00, acc_en} - {1'b0, mag, 1'b0};
  assign dif_abs = dif[DW-1] ? -dif : dif;

  always_ff @(posedge clk) begin
    if (cmd.metric_load) begin
      metric <= dif_abs[cpts_pkg::METRIC_W-1:0];
    end
  end

  // Best offset tracking
  always_ff @(posedge clk) begin
    if (rst || cmd.best_init) begin
      best_metric <= {1'b0, cfg.metric_bound};
      best_index  <= '0;
      b_re  <= '0;
      b_im  <= '0;
      b_en  <= '0;
      b_mag <= '0;
    end else if (cmd.best_update) begin
      if (cmd.first) begin
        b_re  <= acc_re;
        b_im  <= acc_im;
        b_en  <= acc_en;
        b_mag <= mag;
      end
      if (metric < best_metric) begin
        best_metric <= metric;
        best_index  <= cmd.offset;
        b_re  <= acc_re;
        b_im  <= acc_im;
        b_en  <= acc_en;
        b_mag <= mag;
      end
    end
  end

  // Ratio and CORDIC helpers
  assign ua     = b_re[W-1] ? W'(-b_re) : W'(b_re);
  assign ub     = b_im[W-1] ? W'(-b_im) : W'(b_im);
  assign rt     = {1'b0, rm, 1'b0} - {2'b00, b_en};
  assign dx     = y >>> pc;
  assign dy     = x >>> pc;
  assign atan_s = signed'(cpts_pkg::atan_unit(pc));

  assign post_done = (phase == cpts_pkg::P_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cpts_pkg::P_IDLE;
      pc    <= '0;
    end else begin
      case (phase)
        cpts_pkg::P_IDLE: begin
          if (cmd.post_start) begin
            rm  <= b_mag;
            q   <= '0;
            pc  <= '0;
            x   <= b_re;
            y   <= b_im;
            mx  <= (ua > ub) ? ua : ub;
            ang <= '0;
            if (b_en == '0) begin
              phase <= cpts_pkg::P_SHIFT;
            end else if (b_mag >= b_en) begin
              q     <= '1;
              phase <= cpts_pkg::P_SHIFT;
            end else begin
              phase <= cpts_pkg::P_RATIO;
            end
          end
        end
        // One quotient bit per cycle
        cpts_pkg::P_RATIO: begin
          if (!rt[DW-1]) begin
            rm <= rt[W-1:0];
            q  <= {q[cpts_pkg::RATIO_W-2:0], 1'b1};
          end else begin
            rm <= {rm[W-2:0], 1'b0};
            q  <= {q[cpts_pkg::RATIO_W-2:0], 1'b0};
          end
          pc <= pc + 1'b1;
          if (pc == cpts_pkg::STEP_W'(cpts_pkg::RATIO_STEPS - 1)) begin
            pc    <= '0;
            phase <= cpts_pkg::P_SHIFT;
          end
        end
        // Scale down until both parts fit the CORDIC range
        cpts_pkg::P_SHIFT: begin
          if (mx == '0) begin
            phase <= cpts_pkg::P_DONE;
          end else if (|mx[W-1:cpts_pkg::CORDIC_IN_BITS]) begin
            x  <= x >>> 1;
            y  <= y >>> 1;
            mx <= mx >> 1;
          end else begin
            phase <= cpts_pkg::P_QUAD;
          end
        end
        // Fold left half plane by a quarter turn
        cpts_pkg::P_QUAD: begin
          if (x[W-1]) begin
            if (!y[W-1]) begin
              x   <= y;
              y   <= -x;
              ang <= cpts_pkg::ANG_W'(cpts_pkg::QUARTER_TURN);
            end else begin
              x   <= -y;
              y   <= x;
              ang <= -cpts_pkg::ANG_W'(cpts_pkg::QUARTER_TURN);
            end
          end
          pc    <= '0;
          phase <= cpts_pkg::P_ROT;
        end
        // Vectoring rotations, early exit on zero residue
        cpts_pkg::P_ROT: begin
          if (y == '0) begin
            phase <= cpts_pkg::P_DONE;
          end else begin
            if (!y[W-1]) begin
              x   <= x + dx;
              y   <= y - dy;
              ang <= ang + atan_s;
            end else begin
              x   <= x - dx;
              y   <= y + dy;
              ang <= ang - atan_s;
            end
            pc <= pc + 1'b1;
            if (pc == cpts_pkg::STEP_W'(cpts_pkg::CORDIC_STEPS - 1)) begin
              phase <= cpts_pkg::P_DONE;
            end
          end
        end
        cpts_pkg::P_DONE: begin
          phase <= cpts_pkg::P_IDLE;
        end
        default: phase <= cpts_pkg::P_IDLE;
      endcase
    end
  end

  // Result word register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      best_offset <= best_index;
      corr_ratio  <= q;
      corr_phase  <= ang[cpts_pkg::PHASE_W-1:0];
    end
  end

endmodule

@@ hw/rtl/cyclic_prefix_timing_search_top.sv @@
// Capture: one sample word per cycle while not stalled; the word that fills
// the frame starts the search and the input stalls until the result is loaded.
// Search: per offset a setup step, symbol_count*guard_len correlation reads,
// then drain, magnitude (squares, then root) and compare; ratio and phase
// follow after the last offset. Sync reset clears control and restores
// register defaults; the sample store is not cleared.
// ----------------------------------------------------------------------------
// cyclic_prefix_timing_search_top: cyclic prefix timing search
// Captures I/Q samples, searches all symbol start offsets for the best
// cyclic-prefix match and reports offset, correlation ratio and phase.
// ----------------------------------------------------------------------------
module cyclic_prefix_timing_search_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [cpts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cpts_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [cpts_pkg::IN_W-1:0]     sample_i,
  input  logic signed [cpts_pkg::IN_W-1:0]     sample_q,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cpts_pkg::OFF_W-1:0]           best_offset,
  output logic [cpts_pkg::RATIO_W-1:0]         corr_ratio,
  output logic signed [cpts_pkg::PHASE_W-1:0]  corr_phase
);

  cpts_pkg::cpts_cmd_t  cmd;
  cpts_pkg::cpts_cfg_t  cfg;
  cpts_pkg::cpts_stat_t stat;

  logic signed [cpts_pkg::ACC_W-1:0] acc_re, acc_im;
  logic        [cpts_pkg::ACC_W-1:0] acc_en;
  logic        [cpts_pkg::MAG_W-1:0] mag;
  logic corr_busy, mag_done, post_done, out_free;

  assign stat.corr_busy = corr_busy;
  assign stat.mag_done  = mag_done;
  assign stat.post_done = post_done;
  assign stat.out_free  = out_free;

  cpts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd),
    .cfg       (cfg)
  );

  cpts_corr u_corr (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .sample_i (sample_i),
    .sample_q (sample_q),
    .acc_re   (acc_re),
    .acc_im   (acc_im),
    .acc_en   (acc_en),
    .busy     (corr_busy)
  );

  cpts_mag u_mag (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mag_start),
    .re    (acc_re),
    .im    (acc_im),
    .mag   (mag),
    .done  (mag_done)
  );

  cpts_eval u_eval (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .acc_re      (acc_re),
    .acc_im      (acc_im),
    .acc_en      (acc_en),
    .mag         (mag),
    .out_stall   (out_stall),
    .post_done   (post_done),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .best_offset (best_offset),
    .corr_ratio  (corr_ratio),
    .corr_phase  (corr_phase)
  );

endmodule
